// ----- rtl/bgt_pkg.sv -----
// Package for the barrier group table: sizes, operation codes, command and
// queue types shared by the front end, the command queue and the back end.
// No dependencies.
package bgt_pkg;

   // Table sizes
   localparam int GROUP_SLOTS  = 16;
   localparam int MEMBER_SLOTS = 16;
   localparam int KEY_BYTES    = 8;
   localparam int MIN_MEMBERS  = 2;
   localparam int QUEUE_DEPTH  = 2;

   // Field widths
   localparam int OP_W     = 2;
   localparam int KEY_W    = 64;
   localparam int COUNT_W  = 5;
   localparam int SLOT_W   = 4;
   localparam int MEMBER_W = 4;
   localparam int GIU_W    = 5;
   localparam int QPTR_W   = 1;
   localparam int QCNT_W   = 2;

   localparam logic [KEY_W-1:0]   KEY_MASK       = {KEY_W{1'b1}} >> (KEY_W - 8 * KEY_BYTES);
   localparam logic [COUNT_W-1:0] MIN_MEMBERS_C  = COUNT_W'(MIN_MEMBERS);
   localparam logic [COUNT_W-1:0] MEMBER_SLOTS_C = COUNT_W'(MEMBER_SLOTS);
   localparam logic [GIU_W-1:0]   GROUP_SLOTS_C  = GIU_W'(GROUP_SLOTS);
   localparam logic [QCNT_W-1:0]  QUEUE_DEPTH_C  = QCNT_W'(QUEUE_DEPTH);

   // Operation codes on the request channel
   localparam logic [OP_W-1:0] OP_BEGIN  = 2'd0;
   localparam logic [OP_W-1:0] OP_ARRIVE = 2'd1;
   localparam logic [OP_W-1:0] OP_CHECK  = 2'd2;

   // Result status codes
   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_REJ = 1'b1;

   typedef enum logic [1:0] {
      CMD_BEGIN,
      CMD_ARRIVE,
      CMD_CHECK,
      CMD_REJECT
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type          kind;
      logic [KEY_W-1:0]      key;
      logic [COUNT_W-1:0]    count;
      logic [SLOT_W-1:0]     group_slot;
      logic [MEMBER_W-1:0]   member_slot;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_SEARCH,
      BK_EXEC
   } back_state_type;

endpackage

// ----- rtl/bgt_front.sv -----
// Front end of the barrier group table: classifies request items into
// commands and pushes them into the command queue. Depends on bgt_pkg.
module bgt_front
   import bgt_pkg::*;
(
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [OP_W-1:0]      req_operation,
   input  logic [KEY_W-1:0]     req_group_key,
   input  logic [COUNT_W-1:0]   req_headcount,
   input  logic [SLOT_W-1:0]    req_group_slot,
   input  logic [MEMBER_W-1:0]  req_member_slot,
   input  q_status_type         q_stat,
   output logic                 q_push,
   output cmd_type              q_data
);

   logic count_ok;

   // Hold the request while the queue is full
   assign req_stall = q_stat.full;
   assign q_push    = req_valid & ~q_stat.full;

   assign count_ok = req_headcount inside {[MIN_MEMBERS_C:MEMBER_SLOTS_C]};

   // Classify: bad counts and unused codes become rejects
   always_comb begin
      q_data.key         = req_group_key & KEY_MASK;
      q_data.count       = req_headcount;
      q_data.group_slot  = req_group_slot;
      q_data.member_slot = req_member_slot;
      case (req_operation)
         OP_BEGIN:  q_data.kind = count_ok ? CMD_BEGIN : CMD_REJECT;
         OP_ARRIVE: q_data.kind = CMD_ARRIVE;
         OP_CHECK:  q_data.kind = CMD_CHECK;
         default:   q_data.kind = CMD_REJECT;
      endcase
   end

endmodule

// ----- rtl/bgt_queue.sv -----
// Two-entry command queue between front and back end of the barrier group
// table. Depends on bgt_pkg.
module bgt_queue
   import bgt_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  cmd_type       push_data,
   input  logic          pop,
   output cmd_type       head,
   output q_status_type  stat
);

   cmd_type             mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   cnt_ff, cnt_in;
   logic                do_push, do_pop;

   assign stat.full  = (cnt_ff == QUEUE_DEPTH_C);
   assign stat.empty = (cnt_ff == '0);
   assign do_push    = push & ~stat.full;
   assign do_pop     = pop & ~stat.empty;
   assign head       = mem_ff[rd_ptr_ff];

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Store the pushed command
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- rtl/bgt_back.sv -----
// Back end of the barrier group table: holds the group table, searches keys
// one slot per cycle for begin unless a held result is stalled, updates arrivals
// and fire latches, drives the registered result channel. Depends on bgt_pkg.
module bgt_back
   import bgt_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             q_head,
   input  q_status_type        q_stat,
   output logic                q_pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_status,
   output logic [SLOT_W-1:0]   rsp_assigned_slot,
   output logic                rsp_fire
);

   back_state_type       state_ff, state_in;
   cmd_type              cur_ff;
   logic [GIU_W-1:0]     idx_ff;
   logic [GIU_W-1:0]     giu_ff;
   logic [GROUP_SLOTS-1:0] armed_ff;

   logic [KEY_W-1:0]        key_mem   [GROUP_SLOTS];
   logic [COUNT_W-1:0]      exp_ff    [GROUP_SLOTS];
   logic [COUNT_W-1:0]      tot_ff    [GROUP_SLOTS];
   logic [MEMBER_SLOTS-1:0] bits_ff   [GROUP_SLOTS];
   logic [GROUP_SLOTS-1:0]  fired_ff;

   logic                rsp_valid_ff;
   logic                rsp_status_ff;
   logic [SLOT_W-1:0]   rsp_slot_ff;
   logic                rsp_fire_ff;

   logic                out_free;
   logic                done;
   logic                res_status;
   logic [SLOT_W-1:0]   res_slot;
   logic                res_fire;
   logic                arm_en;
   logic [SLOT_W-1:0]   arm_slot;
   logic                alloc;
   logic                mark_en;
   logic                fire_set;
   logic                idx_adv;
   logic                slot_ok;
   logic [SLOT_W-1:0]   gs;
   logic [MEMBER_W-1:0] ms;

   assign out_free = ~rsp_valid_ff | ~rsp_stall;
   assign gs       = cur_ff.group_slot;
   assign ms       = cur_ff.member_slot;
   assign slot_ok  = ({1'b0, gs} < giu_ff) & armed_ff[gs];

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (!q_stat.empty) begin
               state_in = (q_head.kind == CMD_BEGIN) ? BK_SEARCH : BK_EXEC;
            end
         end
         BK_SEARCH, BK_EXEC: begin
            if (done) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // Per-state control and result
   always_comb begin
      q_pop      = 1'b0;
      done       = 1'b0;
      res_status = STATUS_REJ;
      res_slot   = '0;
      res_fire   = 1'b0;
      arm_en     = 1'b0;
      arm_slot   = gs;
      alloc      = 1'b0;
      mark_en    = 1'b0;
      fire_set   = 1'b0;
      idx_adv    = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            q_pop = ~q_stat.empty;
         end
         BK_SEARCH: begin
            if (out_free) begin
               if (idx_ff == giu_ff) begin
                  // no match among groups in use: allocate or reject
                  done = 1'b1;
                  if (giu_ff < GROUP_SLOTS_C) begin
                     alloc      = 1'b1;
                     arm_en     = 1'b1;
                     arm_slot   = giu_ff[SLOT_W-1:0];
                     res_status = STATUS_OK;
                     res_slot   = giu_ff[SLOT_W-1:0];
                  end
               end else if (key_mem[idx_ff[SLOT_W-1:0]] == cur_ff.key) begin
                  done       = 1'b1;
                  arm_en     = 1'b1;
                  arm_slot   = idx_ff[SLOT_W-1:0];
                  res_status = STATUS_OK;
                  res_slot   = idx_ff[SLOT_W-1:0];
               end else begin
                  idx_adv = 1'b1;
               end
            end
         end
         BK_EXEC: begin
            if (out_free) begin
               done = 1'b1;
               case (cur_ff.kind)
                  CMD_ARRIVE: begin
                     if (slot_ok && ({1'b0, ms} < exp_ff[gs]) && !bits_ff[gs][ms]) begin
                        mark_en    = 1'b1;
                        res_status = STATUS_OK;
                     end
                  end
                  CMD_CHECK: begin
                     if (slot_ok) begin
                        res_status = STATUS_OK;
                        if (!fired_ff[gs] && (tot_ff[gs] >= exp_ff[gs])) begin
                           fire_set = 1'b1;
                           res_fire = 1'b1;
                        end
                     end
                  end
                  default: res_status = STATUS_REJ;
               endcase
            end
         end
         default: q_pop = 1'b0;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         giu_ff       <= '0;
         armed_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (alloc) begin
            giu_ff <= giu_ff + 1'b1;
         end
         if (arm_en) begin
            armed_ff[arm_slot] <= 1'b1;
         end
         if (done) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Current command, search index and result payload
   always_ff @(posedge clock) begin
      if (q_pop) begin
         cur_ff <= q_head;
         idx_ff <= '0;
      end else if (idx_adv) begin
         idx_ff <= idx_ff + 1'b1;
      end
      if (done) begin
         rsp_status_ff <= res_status;
         rsp_slot_ff   <= res_slot;
         rsp_fire_ff   <= res_fire;
      end
   end

   // Group table updates
   always_ff @(posedge clock) begin
      if (alloc) begin
         key_mem[giu_ff[SLOT_W-1:0]] <= cur_ff.key;
      end
      if (arm_en) begin
         exp_ff[arm_slot]   <= cur_ff.count;
         tot_ff[arm_slot]   <= '0;
         bits_ff[arm_slot]  <= '0;
         fired_ff[arm_slot] <= 1'b0;
      end
      if (mark_en) begin
         bits_ff[gs][ms] <= 1'b1;
         tot_ff[gs]      <= tot_ff[gs] + 1'b1;
      end
      if (fire_set) begin
         fired_ff[gs] <= 1'b1;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_assigned_slot = rsp_slot_ff;
   assign rsp_fire          = rsp_fire_ff;

endmodule

// ----- rtl/barrier_group_table.sv -----
// Top level of the barrier group table: front end, command queue and back end.
// Depends on bgt_pkg, bgt_front, bgt_queue and bgt_back.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  operation, group_key, headcount,
//                                            group_slot, member_slot
//   rsp      out        rsp_valid/rsp_stall  status, assigned_slot, fire
//
// Arrive, check and rejected items are popped from the queue in the idle
// state, then update the table and load the result register once it is free.
// Begin walks the key store one slot per cycle while no stalled result is
// held, up to the matching key or, for a new key, past the groups in use.
// Reset is synchronous and empties the table at once; no clearing pass.
// A stalled result holds the back end; the two-entry queue accepts until full.
module barrier_group_table
   import bgt_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [OP_W-1:0]      req_operation,
   input  logic [KEY_W-1:0]     req_group_key,
   input  logic [COUNT_W-1:0]   req_headcount,
   input  logic [SLOT_W-1:0]    req_group_slot,
   input  logic [MEMBER_W-1:0]  req_member_slot,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_status,
   output logic [SLOT_W-1:0]    rsp_assigned_slot,
   output logic                 rsp_fire
);

   q_status_type q_stat;
   logic         q_push;
   logic         q_pop;
   cmd_type      q_data;
   cmd_type      q_head;

   // Classify and enqueue
   bgt_front u_front (
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_group_key    (req_group_key),
      .req_headcount    (req_headcount),
      .req_group_slot   (req_group_slot),
      .req_member_slot  (req_member_slot),
      .q_stat           (q_stat),
      .q_push           (q_push),
      .q_data           (q_data)
   );

   // Decouple front and back
   bgt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_data),
      .pop       (q_pop),
      .head      (q_head),
      .stat      (q_stat)
   );

   // Execute against the group table
   bgt_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_head            (q_head),
      .q_stat            (q_stat),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_assigned_slot (rsp_assigned_slot),
      .rsp_fire          (rsp_fire)
   );

endmodule

// ----- sim/barrier_group_table_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for barrier_group_table: a directed opening, then barrier
// rounds mixed with noise, with random pauses on both channels. Depends on bgt_pkg
// and the barrier_group_table RTL.
module barrier_group_table_test;
   import bgt_pkg::*;

   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int KEY_POOL     = 24;
   localparam int TARGET_ITEMS = 1600;
   localparam int MAX_PAUSE    = 14;
   localparam int DRAIN_CYCLES = 64;
   localparam int CYCLE_LIMIT  = 400000;

   typedef struct packed {
      logic [OP_W-1:0]     op;
      logic [KEY_W-1:0]    key;
      logic [COUNT_W-1:0]  count;
      logic [SLOT_W-1:0]   gslot;
      logic [MEMBER_W-1:0] mslot;
   } barrier_request_type;

   typedef struct packed {
      logic              status;
      logic [SLOT_W-1:0] slot;
      logic              fire;
   } barrier_result_type;

   logic                clock;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [OP_W-1:0]     req_operation = OP_BEGIN;
   logic [KEY_W-1:0]    req_group_key = '0;
   logic [COUNT_W-1:0]  req_headcount = '0;
   logic [SLOT_W-1:0]   req_group_slot = '0;
   logic [MEMBER_W-1:0] req_member_slot = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic                rsp_status;
   logic [SLOT_W-1:0]   rsp_assigned_slot;
   logic                rsp_fire;

   barrier_group_table dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_operation     (req_operation),
      .req_group_key     (req_group_key),
      .req_headcount     (req_headcount),
      .req_group_slot    (req_group_slot),
      .req_member_slot   (req_member_slot),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_assigned_slot (rsp_assigned_slot),
      .rsp_fire          (rsp_fire)
   );

   // Predicted table contents
   logic [GIU_W-1:0]        live_groups;
   logic [KEY_W-1:0]        group_keys     [GROUP_SLOTS];
   logic                    group_armed    [GROUP_SLOTS];
   logic [COUNT_W-1:0]      members_needed [GROUP_SLOTS];
   logic [COUNT_W-1:0]      members_seen   [GROUP_SLOTS];
   logic [MEMBER_SLOTS-1:0] seen_bits      [GROUP_SLOTS];
   logic                    fire_latched   [GROUP_SLOTS];

   // Stimulus plan: keys allocated so far, in slot order
   logic [KEY_W-1:0] plan_keys[$];
   logic [KEY_W-1:0] key_pool [KEY_POOL];

   barrier_request_type pending_items[$];
   barrier_result_type  expected_results[$];

   int items_total = 0;
   int items_accepted = 0;
   int cycle_count = 0;
   int send_pause = 0;
   int take_pause = 0;
   bit send_calm = 1'b0;
   bit take_calm = 1'b0;
   bit mismatch_seen = 1'b0;

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   // Apply one item to the predicted table and return the result it should give
   function automatic barrier_result_type apply_barrier_op(
      input logic [OP_W-1:0]     op,
      input logic [KEY_W-1:0]    raw_key,
      input logic [COUNT_W-1:0]  count,
      input logic [SLOT_W-1:0]   gs,
      input logic [MEMBER_W-1:0] ms
   );
      barrier_result_type res;
      logic [KEY_W-1:0]   key;
      int                 hit;
      int                 i;
      res.status = STATUS_REJ;
      res.slot   = '0;
      res.fire   = 1'b0;
      key = raw_key & KEY_MASK;
      hit = -1;
      case (op)
         OP_BEGIN: begin
            if (count >= MIN_MEMBERS_C && count <= MEMBER_SLOTS_C) begin
               // match a live key, else take the next free slot
               for (i = 0; i < int'(live_groups); i++)
                  if (hit < 0 && group_keys[i] == key) hit = i;
               if (hit < 0 && live_groups < GROUP_SLOTS_C) begin
                  hit = int'(live_groups);
                  group_keys[hit] = key;
                  live_groups = live_groups + 1'b1;
               end
               if (hit >= 0) begin
                  group_armed[hit]    = 1'b1;
                  members_needed[hit] = count;
                  members_seen[hit]   = '0;
                  seen_bits[hit]      = '0;
                  fire_latched[hit]   = 1'b0;
                  res.status = STATUS_OK;
                  res.slot   = SLOT_W'(hit);
               end
            end
         end
         OP_ARRIVE: begin
            // mark each member once
            if (gs < live_groups && group_armed[gs] && ms < members_needed[gs] &&
                !seen_bits[gs][ms]) begin
               seen_bits[gs][ms] = 1'b1;
               members_seen[gs]  = members_seen[gs] + 1'b1;
               res.status = STATUS_OK;
            end
         end
         OP_CHECK: begin
            if (gs < live_groups && group_armed[gs]) begin
               res.status = STATUS_OK;
               if (!fire_latched[gs] && members_seen[gs] >= members_needed[gs]) begin
                  fire_latched[gs] = 1'b1;
                  res.fire = 1'b1;
               end
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   function automatic void report_mismatch(string field, logic [7:0] want, logic [7:0] got);
      mismatch_seen = 1'b1;
      $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
   endfunction

   task automatic push_request(
      input logic [OP_W-1:0]     op,
      input logic [KEY_W-1:0]    key,
      input logic [COUNT_W-1:0]  count,
      input logic [SLOT_W-1:0]   gslot,
      input logic [MEMBER_W-1:0] mslot
   );
      barrier_request_type item;
      item.op    = op;
      item.key   = key;
      item.count = count;
      item.gslot = gslot;
      item.mslot = mslot;
      pending_items.push_back(item);
   endtask

   // Arrive or check on one slot; fill the unused fields with noise
   task automatic push_table_op(input logic [OP_W-1:0] op, input int slot, input int member);
      push_request(op, {$urandom, $urandom}, COUNT_W'($urandom_range(0, 31)),
                   SLOT_W'(slot), MEMBER_W'(member));
   endtask

   // Queue a begin and track which slot it lands in (-1 when rejected)
   task automatic queue_begin(input logic [KEY_W-1:0] key, input logic [COUNT_W-1:0] count,
                              output int slot);
      int i;
      push_request(OP_BEGIN, key, count, SLOT_W'($urandom_range(0, 15)),
                   MEMBER_W'($urandom_range(0, 15)));
      slot = -1;
      if (count >= MIN_MEMBERS_C && count <= MEMBER_SLOTS_C) begin
         for (i = 0; i < plan_keys.size(); i++)
            if (slot < 0 && plan_keys[i] == (key & KEY_MASK)) slot = i;
         if (slot < 0 && plan_keys.size() < GROUP_SLOTS) begin
            slot = plan_keys.size();
            plan_keys.push_back(key & KEY_MASK);
         end
      end
   endtask

   // One barrier round: arm a group, bring members in shuffled order, check it
   task automatic run_round();
      logic [KEY_W-1:0] key;
      int               n;
      int               slot;
      int               reach;
      int               j;
      int               k;
      int               tmp;
      int               order [MEMBER_SLOTS];
      key = ($urandom_range(0, 7) == 0) ? {$urandom, $urandom}
                                         : key_pool[$urandom_range(0, KEY_POOL - 1)];
      n = ($urandom_range(0, 4) == 0) ? $urandom_range(7, MEMBER_SLOTS)
                                       : $urandom_range(MIN_MEMBERS, 6);
      queue_begin(key, COUNT_W'(n), slot);
      if (slot < 0) return;
      for (j = 0; j < n; j++) order[j] = j;
      for (j = n - 1; j > 0; j--) begin
         k = $urandom_range(0, j);
         tmp = order[j];
         order[j] = order[k];
         order[k] = tmp;
      end
      // leave some rounds short of members
      reach = ($urandom_range(0, 7) == 0) ? $urandom_range(0, n - 1) : n;
      for (j = 0; j < reach; j++) begin
         push_table_op(OP_ARRIVE, slot, order[j]);
         case ($urandom_range(0, 11))
            0, 1: push_table_op(OP_CHECK, slot, $urandom_range(0, 15));
            2: push_table_op(OP_ARRIVE, slot, order[$urandom_range(0, j)]);
            3: begin
               if (n < MEMBER_SLOTS)
                  push_table_op(OP_ARRIVE, slot, $urandom_range(n, MEMBER_SLOTS - 1));
            end
            4: begin
               push_table_op($urandom_range(0, 1) ? OP_ARRIVE : OP_CHECK,
                             $urandom_range(0, plan_keys.size() - 1), $urandom_range(0, 15));
            end
            default: ;
         endcase
      end
      push_table_op(OP_CHECK, slot, $urandom_range(0, 15));
      if ($urandom_range(0, 1)) push_table_op(OP_CHECK, slot, $urandom_range(0, 15));
   endtask

   // Fully random item, any operation code
   task automatic push_noise();
      logic [OP_W-1:0]  op;
      logic [KEY_W-1:0] key;
      int               slot;
      op  = OP_W'($urandom_range(0, 3));
      key = $urandom_range(0, 1) ? key_pool[$urandom_range(0, KEY_POOL - 1)]
                                 : {$urandom, $urandom};
      if (op == OP_BEGIN)
         queue_begin(key, COUNT_W'($urandom_range(0, 31)), slot);
      else
         push_request(op, key, COUNT_W'($urandom_range(0, 31)),
                      SLOT_W'($urandom_range(0, 15)), MEMBER_W'($urandom_range(0, 15)));
   endtask

   // Drive items from the pending queue; hold while stalled, pause between items
   always @(posedge clock) begin : request_driver
      barrier_request_type item;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && req_stall)) begin
         if (req_valid) begin
            expected_results.push_back(apply_barrier_op(req_operation, req_group_key,
               req_headcount, req_group_slot, req_member_slot));
            items_accepted++;
            if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
            send_pause = send_calm ? 0 : $urandom_range(0, MAX_PAUSE);
         end
         if (send_pause > 0 || pending_items.size() == 0) begin
            if (send_pause > 0) send_pause--;
            req_valid <= 1'b0;
         end else begin
            item = pending_items.pop_front();
            req_operation    <= item.op;
            req_group_key    <= item.key;
            req_headcount    <= item.count;
            req_group_slot   <= item.gslot;
            req_member_slot  <= item.mslot;
            req_valid        <= 1'b1;
         end
      end
   end

   // Take results, compare against the oldest prediction, stall at random
   always @(posedge clock) begin : result_monitor
      barrier_result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               mismatch_seen = 1'b1;
               $display("%0t: result with none expected: status %0b slot %0d fire %0b",
                        $time, rsp_status, rsp_assigned_slot, rsp_fire);
            end else begin
               want = expected_results.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch("status", want.status, rsp_status);
               if (rsp_assigned_slot !== want.slot)
                  report_mismatch("assigned_slot", want.slot, rsp_assigned_slot);
               if (rsp_fire !== want.fire)
                  report_mismatch("fire", want.fire, rsp_fire);
            end
            if ($urandom_range(0, 39) == 0) take_calm = !take_calm;
            take_pause = take_calm ? 0 : $urandom_range(0, MAX_PAUSE);
         end
         if (take_pause > 0) begin
            take_pause--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Bound the run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("barrier_group_table_test: FAIL");
         $finish;
      end
   end

   initial begin : stimulus
      int slot;
      int i;
      live_groups = '0;
      for (i = 0; i < GROUP_SLOTS; i++) begin
         group_keys[i]     = '0;
         group_armed[i]    = 1'b0;
         members_needed[i] = '0;
         members_seen[i]   = '0;
         seen_bits[i]      = '0;
         fire_latched[i]   = 1'b0;
      end
      key_pool[0] = '0;
      key_pool[1] = '1;
      for (i = 2; i < KEY_POOL; i++) key_pool[i] = {$urandom, $urandom};

      // Directed: empty table, unused code, bad counts
      push_request(OP_ARRIVE, '0, '0, 4'd0, 4'd0);
      push_request(OP_CHECK, '1, 5'd31, 4'd15, 4'd15);
      push_request(OP_UNUSED, '1, 5'd31, 4'd15, 4'd15);
      queue_begin('0, 5'd0, slot);
      queue_begin('0, 5'd1, slot);
      queue_begin('0, 5'd17, slot);
      queue_begin('0, 5'd31, slot);
      // Directed: smallest and largest groups
      queue_begin('0, 5'd2, slot);
      queue_begin('1, 5'd16, slot);
      push_table_op(OP_CHECK, 0, 0);
      push_table_op(OP_ARRIVE, 0, 2);
      push_table_op(OP_ARRIVE, 0, 0);
      push_table_op(OP_ARRIVE, 0, 0);
      push_table_op(OP_ARRIVE, 0, 1);
      push_table_op(OP_CHECK, 0, 0);
      push_table_op(OP_CHECK, 0, 0);
      push_table_op(OP_ARRIVE, 1, 15);
      push_table_op(OP_ARRIVE, 2, 0);
      // Directed: re-arm a fired group
      queue_begin('0, 5'd3, slot);
      push_table_op(OP_CHECK, 0, 0);
      push_request(OP_UNUSED, '0, '0, '0, '0);

      // Random: mostly barrier rounds, some noise
      while (pending_items.size() < TARGET_ITEMS) begin
         if ($urandom_range(0, 4) == 0) push_noise();
         else run_round();
      end
      items_total = pending_items.size();

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (items_accepted < items_total) @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (!mismatch_seen) begin
         $display("barrier_group_table_test: PASS");
      end else begin
         $display("barrier_group_table_test: FAIL");
      end
      $finish;
   end

endmodule
